@@ rtl/obb_pkg.sv @@
// Shared widths, types and the pipeline control struct for the oriented-box bounding unit.
package obb_pkg;

	localparam int COORD_W = 24;
	localparam int ENT_W = 16;
	localparam int ROW_W = 3 * ENT_W;
	localparam int HALF_W = 23;
	localparam int FRAC_SHIFT = 14;
	localparam int MULT_W = ENT_W + HALF_W + 1;
	localparam int PROD_W = ENT_W + HALF_W;
	localparam int MAG_W = PROD_W;
	localparam int EXT_W = MAG_W + 1;
	localparam int ACC_W = EXT_W + 2;
	localparam int RND_W = ACC_W - FRAC_SHIFT;
	localparam int NUM_STG = 4;
	localparam int NUM_AX = 3;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [ROW_W-1:0] row_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [EXT_W-1:0] ext_t;
	typedef logic signed [RND_W-1:0] rnd_t;

	// Per-stage load enables from the valid/ready chain.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} obb_ctl_t;

endpackage

@@ rtl/obb_box_if.sv @@
// Input channel carrying one oriented box per beat.
interface obb_box_if;
	logic valid;
	logic ready;
	obb_pkg::coord_t center_x;
	obb_pkg::coord_t center_y;
	obb_pkg::coord_t center_z;
	obb_pkg::row_t rot_row0;
	obb_pkg::row_t rot_row1;
	obb_pkg::row_t rot_row2;
	obb_pkg::half_t half_x;
	obb_pkg::half_t half_y;
	obb_pkg::half_t half_z;

	modport source (
		output valid, center_x, center_y, center_z, rot_row0, rot_row1, rot_row2,
		output half_x, half_y, half_z,
		input ready
	);
	modport sink (
		input valid, center_x, center_y, center_z, rot_row0, rot_row1, rot_row2,
		input half_x, half_y, half_z,
		output ready
	);
endinterface

@@ rtl/obb_aabb_if.sv @@
// Output channel carrying one axis-aligned box per beat.
interface obb_aabb_if;
	logic valid;
	logic ready;
	obb_pkg::coord_t min_x;
	obb_pkg::coord_t min_y;
	obb_pkg::coord_t min_z;
	obb_pkg::coord_t max_x;
	obb_pkg::coord_t max_y;
	obb_pkg::coord_t max_z;

	modport source (
		output valid, min_x, min_y, min_z, max_x, max_y, max_z,
		input ready
	);
	modport sink (
		input valid, min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);
endinterface

@@ rtl/obb_ctrl.sv @@
// Valid bits and stall chain for the four pipeline stages.
module obb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output obb_pkg::obb_ctl_t ctl
);
	import obb_pkg::*;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] en;

	// A stage may load when it is empty or its contents move on in the same cycle.
	always_comb begin
		en[NUM_STG-1] = !vld_q[NUM_STG-1] || out_ready;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STG-1];
	assign ctl.en_s1 = en[0];
	assign ctl.en_s2 = en[1];
	assign ctl.en_s3 = en[2];
	assign ctl.en_s4 = en[3];

`ifndef ASSERT_OFF
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted beat did not reach the first stage");
	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && !en[1] |=> vld_q[0])
		else $error("first stage lost a beat while the next stage was stalled");
	a_out_from_prev: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_q[NUM_STG-1]) |-> $past(vld_q[NUM_STG-2]))
		else $error("output became valid without a beat in the stage before it");
`endif
endmodule

@@ rtl/obb_prod.sv @@
// First stage: the nine products of matrix entries and half extents.
module obb_prod (
	input  logic                                    clk,
	input  logic                                    en,
	input  obb_pkg::row_t  [obb_pkg::NUM_AX-1:0]    rot,
	input  obb_pkg::half_t [obb_pkg::NUM_AX-1:0]    half,
	input  obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   ctr,
	output obb_pkg::prod_t [obb_pkg::NUM_AX-1:0][obb_pkg::NUM_AX-1:0] prod_s1,
	output obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   ctr_s1
);
	import obb_pkg::*;

	logic signed [MULT_W-1:0] full [NUM_AX][NUM_AX];

	always_comb begin
		for (int k = 0; k < NUM_AX; k++) begin
			for (int j = 0; j < NUM_AX; j++) begin
				full[k][j] = $signed(rot[k][ENT_W*j +: ENT_W]) * $signed({1'b0, half[j]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_AX; k++) begin
				for (int j = 0; j < NUM_AX; j++) begin
					prod_s1[k][j] <= full[k][j][PROD_W-1:0];
				end
			end
			ctr_s1 <= ctr;
		end
	end
endmodule

@@ rtl/obb_sum.sv @@
// Second stage: per axis, the sum of product magnitudes gives the box extent.
module obb_sum (
	input  logic                                    clk,
	input  logic                                    en,
	input  obb_pkg::prod_t [obb_pkg::NUM_AX-1:0][obb_pkg::NUM_AX-1:0] prod_s1,
	input  obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   ctr_s1,
	output obb_pkg::ext_t  [obb_pkg::NUM_AX-1:0]    ext_s2,
	output obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   ctr_s2
);
	import obb_pkg::*;

	logic [MAG_W-1:0] mag [NUM_AX][NUM_AX];
	ext_t ext [NUM_AX];

	// Choosing the sign of each half extent independently, the extreme corner adds
	// every product with its own sign, so the extent is the sum of magnitudes.
	always_comb begin
		for (int k = 0; k < NUM_AX; k++) begin
			for (int j = 0; j < NUM_AX; j++) begin
				mag[k][j] = prod_s1[k][j][PROD_W-1] ? MAG_W'(-prod_s1[k][j])
				                                    : MAG_W'(prod_s1[k][j]);
			end
			ext[k] = EXT_W'(mag[k][0]) + EXT_W'(mag[k][1]) + EXT_W'(mag[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_AX; k++) begin
				ext_s2[k] <= ext[k];
			end
			ctr_s2 <= ctr_s1;
		end
	end
endmodule

@@ rtl/obb_fix.sv @@
// Third and fourth stages: extreme corners, rounding to Q12.12 and saturation.
module obb_fix (
	input  logic                                    clk,
	input  logic                                    en_s3,
	input  logic                                    en_s4,
	input  obb_pkg::ext_t  [obb_pkg::NUM_AX-1:0]    ext_s2,
	input  obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   ctr_s2,
	output obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   min_s4,
	output obb_pkg::coord_t [obb_pkg::NUM_AX-1:0]   max_s4
);
	import obb_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC_SHIFT - 1);

	logic signed [ACC_W-1:0] base [NUM_AX];
	logic signed [ACC_W-1:0] lo [NUM_AX];
	logic signed [ACC_W-1:0] hi [NUM_AX];
	rnd_t lo_s3 [NUM_AX];
	rnd_t hi_s3 [NUM_AX];

	function automatic coord_t sat(input rnd_t v);
		coord_t r;
		if (v > RND_W'(COORD_MAX)) begin
			r = COORD_MAX;
		end else if (v < RND_W'(COORD_MIN)) begin
			r = COORD_MIN;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	// Adding half an LSB and dropping the fraction rounds to nearest, ties upward.
	always_comb begin
		for (int k = 0; k < NUM_AX; k++) begin
			base[k] = ACC_W'(ctr_s2[k]) <<< FRAC_SHIFT;
			lo[k] = base[k] - $signed({2'b00, ext_s2[k]}) + HALF_LSB;
			hi[k] = base[k] + $signed({2'b00, ext_s2[k]}) + HALF_LSB;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int k = 0; k < NUM_AX; k++) begin
				lo_s3[k] <= lo[k][ACC_W-1:FRAC_SHIFT];
				hi_s3[k] <= hi[k][ACC_W-1:FRAC_SHIFT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int k = 0; k < NUM_AX; k++) begin
				min_s4[k] <= sat(lo_s3[k]);
				max_s4[k] <= sat(hi_s3[k]);
			end
		end
	end
endmodule

@@ rtl/obb_to_aabb.sv @@
// Top level: axis-aligned bounding box of an oriented box, four-stage pipeline.
// A box moves in turn through the four product, extent, rounding and saturation stages,
// each holding one beat. Throughput: one box per cycle while the output is not stalled;
// a stalled output backs up only the full stages.
// Reset clears the stage valid bits at once; the data registers are not reset.
module obb_to_aabb (
	input logic            clk,
	input logic            arst_n,
	obb_box_if.sink        box,
	obb_aabb_if.source     aabb
);
	import obb_pkg::*;

	obb_ctl_t ctl;

	row_t   [NUM_AX-1:0]         rot;
	half_t  [NUM_AX-1:0]         half;
	coord_t [NUM_AX-1:0]         ctr;
	prod_t  [NUM_AX-1:0][NUM_AX-1:0] prod_s1;
	coord_t [NUM_AX-1:0]         ctr_s1;
	ext_t   [NUM_AX-1:0]         ext_s2;
	coord_t [NUM_AX-1:0]         ctr_s2;
	coord_t [NUM_AX-1:0]         min_s4;
	coord_t [NUM_AX-1:0]         max_s4;

	assign rot  = {box.rot_row2, box.rot_row1, box.rot_row0};
	assign half = {box.half_z, box.half_y, box.half_x};
	assign ctr  = {box.center_z, box.center_y, box.center_x};

	obb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (box.valid),
		.in_ready  (box.ready),
		.out_valid (aabb.valid),
		.out_ready (aabb.ready),
		.ctl       (ctl)
	);

	obb_prod u_prod (
		.clk     (clk),
		.en      (ctl.en_s1),
		.rot     (rot),
		.half    (half),
		.ctr     (ctr),
		.prod_s1 (prod_s1),
		.ctr_s1  (ctr_s1)
	);

	obb_sum u_sum (
		.clk     (clk),
		.en      (ctl.en_s2),
		.prod_s1 (prod_s1),
		.ctr_s1  (ctr_s1),
		.ext_s2  (ext_s2),
		.ctr_s2  (ctr_s2)
	);

	obb_fix u_fix (
		.clk    (clk),
		.en_s3  (ctl.en_s3),
		.en_s4  (ctl.en_s4),
		.ext_s2 (ext_s2),
		.ctr_s2 (ctr_s2),
		.min_s4 (min_s4),
		.max_s4 (max_s4)
	);

	assign aabb.min_x = min_s4[0];
	assign aabb.min_y = min_s4[1];
	assign aabb.min_z = min_s4[2];
	assign aabb.max_x = max_s4[0];
	assign aabb.max_y = max_s4[1];
	assign aabb.max_z = max_s4[2];
endmodule

@@ dv/obb_to_aabb_tb.sv @@
// Self-checking testbench for the oriented-box to axis-aligned-box pipeline.
`timescale 1ns / 1ps

module obb_to_aabb_tb;
	import obb_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_BOXES = 950;
	localparam int MAX_IDLE = 17;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 40;
	localparam logic [ENT_W-1:0] ENT_ONE = 16'h4000;
	localparam logic [ENT_W-1:0] ENT_MAX = 16'h7fff;
	localparam logic [ENT_W-1:0] ENT_MIN = 16'h8000;
	localparam logic [ENT_W-1:0] ENT_ZERO = 16'h0000;
	localparam half_t HALF_MAX = {HALF_W{1'b1}};
	localparam half_t HALF_ONE = 23'd4096;
	localparam longint ROUND_HALF = 64'sd8192;

	typedef enum int {
		SHAPE_TYPICAL,
		SHAPE_RAW,
		SHAPE_EDGE,
		SHAPE_FLAT
	} box_shape_e;

	typedef struct {
		coord_t center_x;
		coord_t center_y;
		coord_t center_z;
		row_t rot_row0;
		row_t rot_row1;
		row_t rot_row2;
		half_t half_x;
		half_t half_y;
		half_t half_z;
	} box_t;

	typedef struct {
		coord_t min_x;
		coord_t min_y;
		coord_t min_z;
		coord_t max_x;
		coord_t max_y;
		coord_t max_z;
	} aabb_t;

	class aabb_scoreboard;
		aabb_t pending_bounds[$];
		int errors;
		int boxes_noted;
		int bounds_checked;
		int saturated_boxes;

		function new();
			errors = 0;
			boxes_noted = 0;
			bounds_checked = 0;
			saturated_boxes = 0;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		// Round to nearest with ties upward, then clamp to the coordinate range.
		function coord_t round_to_q12(longint v);
			longint q;
			q = (v + ROUND_HALF) >>> FRAC_SHIFT;
			if (q > longint'(COORD_MAX))
				q = longint'(COORD_MAX);
			if (q < longint'(COORD_MIN))
				q = longint'(COORD_MIN);
			return coord_t'(q);
		endfunction

		// Corners are summed exactly in Q.26; min and max are taken before rounding.
		function aabb_t predict_bounds(box_t b);
			longint ctr[3];
			longint ent[3][3];
			longint half[3];
			longint lo[3];
			longint hi[3];
			longint acc;
			row_t rows[3];
			aabb_t r;
			ctr[0] = longint'(b.center_x);
			ctr[1] = longint'(b.center_y);
			ctr[2] = longint'(b.center_z);
			rows[0] = b.rot_row0;
			rows[1] = b.rot_row1;
			rows[2] = b.rot_row2;
			half[0] = longint'(b.half_x);
			half[1] = longint'(b.half_y);
			half[2] = longint'(b.half_z);
			for (int k = 0; k < NUM_AX; k++)
				for (int j = 0; j < NUM_AX; j++)
					ent[k][j] = longint'($signed(rows[k][ENT_W*j +: ENT_W]));
			for (int c = 0; c < 8; c++) begin
				for (int k = 0; k < NUM_AX; k++) begin
					acc = ctr[k] <<< FRAC_SHIFT;
					for (int j = 0; j < NUM_AX; j++) begin
						if (c[j])
							acc += ent[k][j] * half[j];
						else
							acc -= ent[k][j] * half[j];
					end
					if (c == 0 || acc < lo[k])
						lo[k] = acc;
					if (c == 0 || acc > hi[k])
						hi[k] = acc;
				end
			end
			r.min_x = round_to_q12(lo[0]);
			r.min_y = round_to_q12(lo[1]);
			r.min_z = round_to_q12(lo[2]);
			r.max_x = round_to_q12(hi[0]);
			r.max_y = round_to_q12(hi[1]);
			r.max_z = round_to_q12(hi[2]);
			return r;
		endfunction

		function void note_box(box_t b);
			aabb_t r;
			r = predict_bounds(b);
			boxes_noted++;
			if (r.min_x == COORD_MIN || r.min_y == COORD_MIN || r.min_z == COORD_MIN ||
				r.max_x == COORD_MAX || r.max_y == COORD_MAX || r.max_z == COORD_MAX)
				saturated_boxes++;
			pending_bounds.push_back(r);
		endfunction

		task check_bounds(aabb_t got);
			aabb_t want;
			coord_t want_f[6];
			coord_t got_f[6];
			string names[6];
			names = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
			if (pending_bounds.size() == 0) begin
				report("output beat with no box outstanding");
				return;
			end
			want = pending_bounds.pop_front();
			bounds_checked++;
			want_f = '{want.min_x, want.min_y, want.min_z, want.max_x, want.max_y, want.max_z};
			got_f = '{got.min_x, got.min_y, got.min_z, got.max_x, got.max_y, got.max_z};
			for (int f = 0; f < 6; f++)
				if (got_f[f] !== want_f[f])
					report($sformatf("result %0d %s: got %0d expected %0d", bounds_checked,
						names[f], got_f[f], want_f[f]));
		endtask

		function int pending();
			return pending_bounds.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int cycle_count = 0;
	bit src_burst;
	bit snk_burst;
	aabb_scoreboard sb;

	obb_box_if box_ch ();
	obb_aabb_if aabb_ch ();

	obb_to_aabb dut (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_ch),
		.aabb   (aabb_ch)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				sb.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function int draw_idle(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	function row_t pack_row(logic [ENT_W-1:0] c0, logic [ENT_W-1:0] c1,
		logic [ENT_W-1:0] c2);
		return {c2, c1, c0};
	endfunction

	function box_t make_box(coord_t cx, coord_t cy, coord_t cz, row_t r0, row_t r1, row_t r2,
		half_t hx, half_t hy, half_t hz);
		box_t b;
		b.center_x = cx;
		b.center_y = cy;
		b.center_z = cz;
		b.rot_row0 = r0;
		b.rot_row1 = r1;
		b.rot_row2 = r2;
		b.half_x = hx;
		b.half_y = hy;
		b.half_z = hz;
		return b;
	endfunction

	// Entries within [-1.0, 1.0], as a real rotation would have.
	function logic [ENT_W-1:0] unit_entry();
		return ENT_W'($urandom_range(0, 32768) - 16384);
	endfunction

	function logic [ENT_W-1:0] edge_entry();
		case ($urandom_range(0, 3))
			0: return ENT_MAX;
			1: return ENT_MIN;
			2: return ENT_ZERO;
			default: return ENT_ONE;
		endcase
	endfunction

	function row_t unit_row();
		return pack_row(unit_entry(), unit_entry(), unit_entry());
	endfunction

	function row_t raw_row();
		return row_t'({$urandom, $urandom});
	endfunction

	function coord_t edge_center();
		if ($urandom_range(0, 1))
			return coord_t'(COORD_MAX - $urandom_range(0, 65535));
		return coord_t'(COORD_MIN + $urandom_range(0, 65535));
	endfunction

	function automatic box_t random_box(box_shape_e shape);
		box_t b;
		case (shape)
			SHAPE_TYPICAL: begin
				b = make_box(coord_t'($urandom_range(0, 1 << 21) - (1 << 20)),
					coord_t'($urandom_range(0, 1 << 21) - (1 << 20)),
					coord_t'($urandom_range(0, 1 << 21) - (1 << 20)),
					unit_row(), unit_row(), unit_row(),
					half_t'($urandom_range(0, 1 << 18)), half_t'($urandom_range(0, 1 << 18)),
					half_t'($urandom_range(0, 1 << 18)));
			end
			SHAPE_RAW: begin
				b = make_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
					raw_row(), raw_row(), raw_row(),
					half_t'($urandom), half_t'($urandom), half_t'($urandom));
			end
			SHAPE_EDGE: begin
				b = make_box(edge_center(), edge_center(), edge_center(),
					raw_row(), unit_row(), raw_row(),
					HALF_MAX - half_t'($urandom_range(0, 4095)), half_t'($urandom),
					half_t'($urandom_range(0, 1 << 20)));
			end
			default: begin
				b = random_box(SHAPE_TYPICAL);
				if ($urandom_range(0, 1))
					b.half_x = '0;
				if ($urandom_range(0, 1))
					b.half_y = '0;
				if ($urandom_range(0, 1))
					b.half_z = '0;
				if ($urandom_range(0, 1))
					b.rot_row1 = pack_row(edge_entry(), edge_entry(), edge_entry());
			end
		endcase
		return b;
	endfunction

	// Holds the beat on the channel until the block takes it.
	task send_box(box_t b);
		int idle;
		idle = draw_idle(src_burst);
		if (idle > 0) begin
			box_ch.valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		box_ch.valid <= 1'b1;
		box_ch.center_x <= b.center_x;
		box_ch.center_y <= b.center_y;
		box_ch.center_z <= b.center_z;
		box_ch.rot_row0 <= b.rot_row0;
		box_ch.rot_row1 <= b.rot_row1;
		box_ch.rot_row2 <= b.rot_row2;
		box_ch.half_x <= b.half_x;
		box_ch.half_y <= b.half_y;
		box_ch.half_z <= b.half_z;
		do
			@(posedge clk);
		while (box_ch.ready !== 1'b1);
		sb.note_box(b);
		if ($urandom_range(0, 39) == 0)
			src_burst = ~src_burst;
	endtask

	initial begin
		aabb_t got;
		int idle;
		aabb_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			idle = draw_idle(snk_burst);
			if (idle > 0) begin
				aabb_ch.ready <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			aabb_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (aabb_ch.valid !== 1'b1);
			got.min_x = aabb_ch.min_x;
			got.min_y = aabb_ch.min_y;
			got.min_z = aabb_ch.min_z;
			got.max_x = aabb_ch.max_x;
			got.max_y = aabb_ch.max_y;
			got.max_z = aabb_ch.max_z;
			sb.check_bounds(got);
			if ($urandom_range(0, 39) == 0)
				snk_burst = ~snk_burst;
		end
	end

	initial begin
		row_t ident0;
		row_t ident1;
		row_t ident2;
		row_t all_max;
		row_t all_min;
		box_t b;
		int pick;
		box_shape_e shape;
		sb = new();
		src_burst = 1'b0;
		snk_burst = 1'b0;
		arst_n <= 1'b0;
		box_ch.valid <= 1'b0;
		box_ch.center_x <= '0;
		box_ch.center_y <= '0;
		box_ch.center_z <= '0;
		box_ch.rot_row0 <= '0;
		box_ch.rot_row1 <= '0;
		box_ch.rot_row2 <= '0;
		box_ch.half_x <= '0;
		box_ch.half_y <= '0;
		box_ch.half_z <= '0;
		ident0 = pack_row(ENT_ONE, ENT_ZERO, ENT_ZERO);
		ident1 = pack_row(ENT_ZERO, ENT_ONE, ENT_ZERO);
		ident2 = pack_row(ENT_ZERO, ENT_ZERO, ENT_ONE);
		all_max = pack_row(ENT_MAX, ENT_MAX, ENT_MAX);
		all_min = pack_row(ENT_MIN, ENT_MIN, ENT_MIN);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_box(make_box('0, '0, '0, '0, '0, '0, '0, '0, '0));
		send_box(make_box('0, '0, '0, ident0, ident1, ident2, HALF_ONE, HALF_ONE, HALF_ONE));
		send_box(make_box(coord_t'(4096), coord_t'(-8192), coord_t'(12288),
			ident0, ident1, ident2, HALF_ONE, 23'd2048, 23'd8192));
		// Positive and negative overflow of every coordinate.
		send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, all_max, all_max, all_max,
			HALF_MAX, HALF_MAX, HALF_MAX));
		send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, all_min, all_min, all_min,
			HALF_MAX, HALF_MAX, HALF_MAX));
		send_box(make_box(COORD_MAX, COORD_MIN, '0, all_min, all_max, all_min,
			HALF_MAX, '0, HALF_ONE));
		send_box(make_box(COORD_MIN, COORD_MAX, COORD_MAX, ident0, ident1, ident2,
			'0, '0, '0));
		// Corners exactly halfway between two output steps round upward.
		send_box(make_box('0, '0, '0, pack_row(16'h0001, ENT_ZERO, ENT_ZERO),
			pack_row(ENT_ZERO, 16'hffff, ENT_ZERO), pack_row(16'h0001, 16'h0001, 16'h0001),
			23'd8192, 23'd8192, 23'd8192));
		send_box(make_box(coord_t'(-1), coord_t'(1), '0, pack_row(16'h0001, ENT_ZERO, ENT_ZERO),
			pack_row(16'h0003, ENT_ZERO, ENT_ZERO), pack_row(16'hfffd, ENT_ZERO, ENT_ZERO),
			23'd8192, '0, '0));
		// Zero extents collapse the box to its center.
		send_box(make_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			raw_row(), raw_row(), raw_row(), '0, '0, '0));
		// Matrices that are not rotations, and one rotation by 45 degrees about z.
		send_box(make_box(coord_t'(1000), coord_t'(-1000), '0, all_max, all_min, all_max,
			HALF_ONE, 23'd100000, 23'd3));
		send_box(make_box('0, '0, '0, pack_row(ENT_MAX, ENT_MIN, ENT_ZERO),
			pack_row(ENT_MIN, ENT_ZERO, ENT_MAX), pack_row(ENT_ZERO, ENT_MAX, ENT_MIN),
			HALF_MAX, HALF_ONE, HALF_MAX));
		send_box(make_box(coord_t'(-4096), coord_t'(4096), coord_t'(-1),
			pack_row(16'h2d41, 16'hd2bf, ENT_ZERO), pack_row(16'h2d41, 16'h2d41, ENT_ZERO),
			ident2, 23'd40960, 23'd20480, 23'd4096));
		for (int i = 0; i < 4; i++)
			send_box(random_box(SHAPE_RAW));

		for (int i = 0; i < RANDOM_BOXES; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				shape = SHAPE_TYPICAL;
			else if (pick < 7)
				shape = SHAPE_RAW;
			else if (pick < 8)
				shape = SHAPE_EDGE;
			else
				shape = SHAPE_FLAT;
			b = random_box(shape);
			send_box(b);
		end
		box_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d boxes sent, %0d bounding boxes compared, %0d mismatches.",
			sb.boxes_noted, sb.bounds_checked, sb.errors);
		$display("Summary: %0d boxes hit coordinate saturation; both sides idled at random.",
			sb.saturated_boxes);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/obb_pkg.sv
rtl/obb_box_if.sv
rtl/obb_aabb_if.sv
rtl/obb_ctrl.sv
rtl/obb_prod.sv
rtl/obb_sum.sv
rtl/obb_fix.sv
rtl/obb_to_aabb.sv
dv/obb_to_aabb_tb.sv
